FILE: hdl/sfr_pkg.sv
// Shared types and constants for the sync frame receiver.
// No dependencies; used by sfr_ctrl, sfr_dp and the top level.
package sfr_pkg;

  localparam int ByteW   = 8;
  localparam int StatW   = 2;
  localparam int LenW    = 6;
  localparam int CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSyncThird  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAcceptType = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMsgLength  = 3'd4;

  // result status codes
  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StFault = 2'd1;
  localparam logic [StatW-1:0] StType  = 2'd2;
  localparam logic [StatW-1:0] StCheck = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic             win_shift;
    logic             win_clr;
    logic             frame_start;
    logic             absorb;
    logic             ck_store;
    logic             err_load;
    logic [StatW-1:0] err_status;
    logic             rep_load;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic sync_hit;
    logic type_ok;
    logic len_one;
    logic body_done;
    logic check_ok;
    logic rep_last;
    logic rep_empty;
  } dp_sts_t;

endpackage

FILE: hdl/sfr_dp.sv
// Datapath of the sync frame receiver: config registers, sync window,
// byte counter, checksum sums, message store and result register.
// Depends on sfr_pkg.
module sfr_dp #(
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic [sfr_pkg::ByteW-1:0]    rx_byte_i,
  input  sfr_pkg::dp_cmd_t             cmd_i,
  input  logic [$clog2(MAX_MESSAGE_BYTES)-1:0] rd_addr_i,
  output sfr_pkg::dp_sts_t             sts_o,
  output logic [sfr_pkg::ByteW-1:0]    out_byte_o,
  output logic [sfr_pkg::StatW-1:0]    out_status_o,
  output logic                         out_last_o
);

  localparam int AW   = $clog2(MAX_MESSAGE_BYTES);
  localparam int CntW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CmpW = (CntW > sfr_pkg::LenW) ? CntW : sfr_pkg::LenW;

  logic [sfr_pkg::ByteW-1:0] sync1_q, sync2_q, sync3_q, type_q;
  logic [sfr_pkg::LenW-1:0]  len_q;
  logic [2*sfr_pkg::ByteW-1:0] win_q, win_d;
  logic [CntW-1:0]           cnt_q, cnt_d, cnt_base, cnt_inc;
  logic [sfr_pkg::ByteW-1:0] sum_lo_q, sum_lo_d, sum_hi_q, sum_hi_d, ck1_q;
  logic [CmpW-1:0]           len_ext, max_c, eff_len;
  logic                      store_we;

  logic [sfr_pkg::ByteW-1:0] mem [MAX_MESSAGE_BYTES];
  logic [sfr_pkg::ByteW-1:0] out_byte_q;
  logic [sfr_pkg::StatW-1:0] out_status_q;
  logic                      out_last_q;

  // effective length: zero acts as one, clipped to the store depth
  assign len_ext = CmpW'(len_q);
  assign max_c   = CmpW'(MAX_MESSAGE_BYTES);
  always_comb begin
    if (len_q == '0) begin
      eff_len = CmpW'(1);
    end else if (len_ext > max_c) begin
      eff_len = max_c;
    end else begin
      eff_len = len_ext;
    end
  end

  // count after absorbing the current byte
  assign cnt_base = cmd_i.frame_start ? '0 : cnt_q;
  assign cnt_inc  = (CmpW'(cnt_base) < max_c) ? cnt_base + CntW'(1) : cnt_base;
  assign store_we = (cmd_i.frame_start || cmd_i.absorb) && (CmpW'(cnt_base) < max_c);

  // running sums
  always_comb begin
    sum_lo_d = sum_lo_q;
    sum_hi_d = sum_hi_q;
    if (cmd_i.frame_start) begin
      sum_lo_d = rx_byte_i;
      sum_hi_d = rx_byte_i;
    end else if (cmd_i.absorb) begin
      sum_lo_d = sum_lo_q + rx_byte_i;
      sum_hi_d = sum_hi_q + sum_lo_d;
    end
  end

  // sync window and counter next values
  always_comb begin
    win_d = win_q;
    if (cmd_i.win_clr) begin
      win_d = '0;
    end else if (cmd_i.win_shift) begin
      win_d = {win_q[sfr_pkg::ByteW-1:0], rx_byte_i};
    end
    cnt_d = (cmd_i.frame_start || cmd_i.absorb) ? cnt_inc : cnt_q;
  end

  // status toward the controller
  always_comb begin
    sts_o.sync_hit  = (win_q[2*sfr_pkg::ByteW-1:sfr_pkg::ByteW] == sync1_q) &&
                      (win_q[sfr_pkg::ByteW-1:0] == sync2_q) && (rx_byte_i == sync3_q);
    sts_o.type_ok   = (rx_byte_i == type_q);
    sts_o.len_one   = (eff_len == CmpW'(1));
    sts_o.body_done = (CmpW'(cnt_inc) >= eff_len);
    sts_o.check_ok  = (ck1_q == sum_lo_q) && (rx_byte_i == sum_hi_q);
    sts_o.rep_last  = ((CntW'(rd_addr_i) + CntW'(1)) == cnt_q);
    sts_o.rep_empty = (cnt_q == '0);
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync1_q  <= '0;
      sync2_q  <= '0;
      sync3_q  <= '0;
      type_q   <= '0;
      len_q    <= sfr_pkg::LenW'(1);
      win_q    <= '0;
      cnt_q    <= '0;
      sum_lo_q <= '0;
      sum_hi_q <= '0;
      ck1_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sfr_pkg::CfgSyncFirst:  sync1_q <= cfg_wdata_i;
          sfr_pkg::CfgSyncSecond: sync2_q <= cfg_wdata_i;
          sfr_pkg::CfgSyncThird:  sync3_q <= cfg_wdata_i;
          sfr_pkg::CfgAcceptType: type_q  <= cfg_wdata_i;
          sfr_pkg::CfgMsgLength:  len_q   <= cfg_wdata_i[sfr_pkg::LenW-1:0];
          default: ;
        endcase
      end
      win_q    <= win_d;
      cnt_q    <= cnt_d;
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
      if (cmd_i.ck_store) begin
        ck1_q <= rx_byte_i;
      end
    end
  end

  // message store and result register (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem[cnt_base[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.err_load) begin
      out_byte_q   <= '0;
      out_status_q <= cmd_i.err_status;
      out_last_q   <= 1'b1;
    end else if (cmd_i.rep_load) begin
      out_byte_q   <= mem[rd_addr_i];
      out_status_q <= sfr_pkg::StOk;
      out_last_q   <= sts_o.rep_last;
    end
  end

  assign out_byte_o   = out_byte_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: hdl/sfr_ctrl.sv
// Controller of the sync frame receiver: frame phase machine, replay
// sequencer and output valid/stall handling. Depends on sfr_pkg.
module sfr_ctrl #(
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          rx_fault_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  sfr_pkg::dp_sts_t              sts_i,
  output sfr_pkg::dp_cmd_t              cmd_o,
  output logic [$clog2(MAX_MESSAGE_BYTES)-1:0] rd_addr_o
);

  localparam int AW = $clog2(MAX_MESSAGE_BYTES);

  typedef enum logic [2:0] {
    PhHunt,
    PhType,
    PhBody,
    PhCk1,
    PhCk2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            rep_q, rep_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            ovld_q, ovld_d;
  logic            acc, out_free;

  // input is held off while replaying or while a result is stuck
  assign in_stall_o = rep_q || (ovld_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_free   = !ovld_q || !out_stall_i;
  assign rd_addr_o  = idx_q;

  // next state and datapath commands
  always_comb begin
    phase_d = phase_q;
    rep_d   = rep_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    if (acc) begin
      if (rx_fault_i) begin
        cmd_o.err_load   = 1'b1;
        cmd_o.err_status = sfr_pkg::StFault;
        cmd_o.win_clr    = 1'b1;
        phase_d          = PhHunt;
      end else begin
        unique case (phase_q)
          PhType: begin
            if (!sts_i.type_ok) begin
              cmd_o.err_load   = 1'b1;
              cmd_o.err_status = sfr_pkg::StType;
              cmd_o.win_clr    = 1'b1;
              phase_d          = PhHunt;
            end else begin
              cmd_o.frame_start = 1'b1;
              phase_d           = sts_i.len_one ? PhCk1 : PhBody;
            end
          end
          PhBody: begin
            cmd_o.absorb = 1'b1;
            if (sts_i.body_done) begin
              phase_d = PhCk1;
            end
          end
          PhCk1: begin
            cmd_o.ck_store = 1'b1;
            phase_d        = PhCk2;
          end
          PhCk2: begin
            cmd_o.win_clr = 1'b1;
            phase_d       = PhHunt;
            if (!sts_i.check_ok) begin
              cmd_o.err_load   = 1'b1;
              cmd_o.err_status = sfr_pkg::StCheck;
            end else if (!sts_i.rep_empty) begin
              rep_d = 1'b1;
              idx_d = '0;
            end
          end
          default: begin
            if (sts_i.sync_hit) begin
              cmd_o.win_clr = 1'b1;
              phase_d       = PhType;
            end else begin
              cmd_o.win_shift = 1'b1;
              phase_d         = PhHunt;
            end
          end
        endcase
      end
    end

    // replay: one stored byte per free output slot
    if (rep_q && out_free) begin
      cmd_o.rep_load = 1'b1;
      idx_d          = idx_q + AW'(1);
      if (sts_i.rep_last) begin
        rep_d = 1'b0;
      end
    end

    if (cmd_o.err_load || cmd_o.rep_load) begin
      ovld_d = 1'b1;
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      rep_q   <= 1'b0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rep_q   <= rep_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;

endmodule

FILE: hdl/sync_frame_receiver_fletcher8_core.sv
// Sync frame receiver with three-byte sync and Fletcher-8 check: top level.
// Instantiates sfr_ctrl and sfr_dp; depends on sfr_pkg.
//
// One received byte enters per accepted beat; the input is stalled only
// while the result register holds a beat that the sink stalls, or while a
// good frame is being replayed. A frame of n stored bytes is replayed from
// the message store through its single registered read port at one beat
// per cycle while the sink does not stall; the input is taken again once
// the last byte has been read. Error results (link fault, unknown type,
// checksum mismatch) are one beat with a zero byte
// and last set. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i: 0..2 sync bytes, 3 accepted type, 4 message length
// (low six bits; zero acts as one, values above MAX_MESSAGE_BYTES clip).
module sync_frame_receiver_fletcher8_core #(
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sfr_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                         rx_fault_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sfr_pkg::ByteW-1:0]    out_byte_o,
  output logic [sfr_pkg::StatW-1:0]    out_status_o,
  output logic                         out_last_o
);

  localparam int AW = $clog2(MAX_MESSAGE_BYTES);

  sfr_pkg::dp_cmd_t cmd;
  sfr_pkg::dp_sts_t sts;
  logic [AW-1:0]    rd_addr;

  sfr_ctrl #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_fault_i (rx_fault_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  sfr_dp #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_byte_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .sts_o       (sts),
    .out_byte_o  (out_byte_o),
    .out_status_o(out_status_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: hdl/sfr_checker.sv
// Port-level checks for the sync frame receiver, bound to the top level.
// Depends on sfr_pkg and sync_frame_receiver_fletcher8_core.
module sfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sfr_pkg::ByteW-1:0]    out_byte_o,
  input logic [sfr_pkg::StatW-1:0]    out_status_o,
  input logic                         out_last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(out_status_o) && $stable(out_last_o))
    else $error("stalled result beat changed");

  // error beats carry a zero byte and close the frame
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != sfr_pkg::StOk) |-> out_last_o && (out_byte_o == '0))
    else $error("malformed error beat");

  // no input taken while a result beat is stuck
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result stalled");

  // replay runs without gaps up to the last byte
  a_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_status_o == sfr_pkg::StOk) && !out_last_o
    |=> out_valid_o && (out_status_o == sfr_pkg::StOk))
    else $error("frame replay broke off");

endmodule

bind sync_frame_receiver_fletcher8_core sfr_checker u_sfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_status_o(out_status_o),
  .out_last_o  (out_last_o)
);

FILE: verif/sfr_frame_checker.sv
// Checker for the sync frame receiver: mirrors config writes, predicts the
// out beats caused by each accepted rx beat and compares them in order.
// Depends on sfr_pkg; instantiated next to the core by the testbench top.
`timescale 1ns / 100ps

module sfr_frame_checker #(
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [sfr_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                         rx_fault_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [sfr_pkg::ByteW-1:0]    out_byte_i,
  input  logic [sfr_pkg::StatW-1:0]    out_status_i,
  input  logic                         out_last_i,
  output int                           outstanding_o,
  output int                           errors_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {PhHunt, PhType, PhBody, PhCk1, PhCk2} rx_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [StatW-1:0] status;
    logic             last;
  } out_beat_t;

  // register copies
  logic [ByteW-1:0] sync_a, sync_b, sync_c, want_type;
  logic [LenW-1:0]  msg_len;

  // frame state
  rx_phase_e        phase;
  logic [15:0]      window;
  logic [LenW-1:0]  count;
  logic [ByteW-1:0] sum_lo, sum_hi, ck_first;
  logic [ByteW-1:0] msg_mem [MAX_MESSAGE_BYTES];

  out_beat_t out_due_q[$];
  int        err_cnt = 0;

  assign errors_o = err_cnt;

  // any error: one zero beat with last set, back to hunting
  task automatic raise_error(input logic [StatW-1:0] st);
    phase  = PhHunt;
    window = '0;
    out_due_q.push_back({8'h00, st, 1'b1});
  endtask

  // buffer a message byte and run both wrapping sums
  task automatic store_byte(input logic [ByteW-1:0] b);
    if (count < MAX_MESSAGE_BYTES) begin
      msg_mem[count] = b;
      count = count + 1'b1;
    end
    sum_lo = sum_lo + b;
    sum_hi = sum_hi + sum_lo;
  endtask

  task automatic take_rx_beat(input logic [ByteW-1:0] b, input logic fault);
    int lim;
    // zero length acts as one, oversize clips to the store depth
    lim = (msg_len == 0) ? 1 : (msg_len > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : msg_len;
    if (fault) begin
      raise_error(StFault);
      return;
    end
    case (phase)
      PhType: begin
        if (b != want_type) begin
          raise_error(StType);
        end else begin
          count  = '0;
          sum_lo = '0;
          sum_hi = '0;
          store_byte(b);
          phase = (count >= lim) ? PhCk1 : PhBody;
        end
      end
      PhBody: begin
        store_byte(b);
        if (count >= lim) phase = PhCk1;
      end
      PhCk1: begin
        ck_first = b;
        phase    = PhCk2;
      end
      PhCk2: begin
        if (ck_first != sum_lo || b != sum_hi) begin
          raise_error(StCheck);
        end else begin
          phase  = PhHunt;
          window = '0;
          for (int i = 0; i < count; i++)
            out_due_q.push_back({msg_mem[i], StOk, (i + 1 == count)});
        end
      end
      default: begin
        // sliding three-byte sync hunt
        if (window[15:8] == sync_a && window[7:0] == sync_b && b == sync_c) begin
          window = '0;
          phase  = PhType;
        end else begin
          phase  = PhHunt;
          window = {window[7:0], b};
        end
      end
    endcase
  endtask

  // compare out beats, predict from rx beats, track config writes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t got, want;
    if (!rst_ni) begin
      sync_a        = '0;
      sync_b        = '0;
      sync_c        = '0;
      want_type     = '0;
      msg_len       = 6'd1;
      phase         = PhHunt;
      window        = '0;
      count         = '0;
      sum_lo        = '0;
      sum_hi        = '0;
      ck_first      = '0;
      out_due_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {out_byte_i, out_status_i, out_last_i};
        if (out_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected out beat: byte %02h status %0d last %0d",
                   $time, got.data, got.status, got.last);
        end else begin
          want = out_due_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display("%0t: out beat mismatch: expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
                     $time, want.data, want.status, want.last,
                     got.data, got.status, got.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_rx_beat(rx_byte_i, rx_fault_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSyncFirst:  sync_a    = cfg_wdata_i;
          CfgSyncSecond: sync_b    = cfg_wdata_i;
          CfgSyncThird:  sync_c    = cfg_wdata_i;
          CfgAcceptType: want_type = cfg_wdata_i;
          CfgMsgLength:  msg_len   = cfg_wdata_i[LenW-1:0];
          default: ;
        endcase
      end
      outstanding_o <= out_due_q.size();
    end
  end

endmodule

FILE: verif/sync_frame_receiver_fletcher8_core_tb.sv
// Testbench top for sync_frame_receiver_fletcher8_core: drives config and
// rx beats (directed frames, then random frames under varying idle/stall).
// Depends on sfr_pkg, the core and sfr_frame_checker.
`timescale 1ns / 100ps

module sync_frame_receiver_fletcher8_core_tb;
  import sfr_pkg::*;

  localparam int MaxMsg     = 32;
  localparam int CycleLimit = 2_000_000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 105;

  typedef enum {FrGood, FrBadType, FrBadSum, FrFault, FrNoise} frame_kind_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [ByteW-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [ByteW-1:0]   rx_byte;
  logic               rx_fault;
  logic               out_valid;
  logic               out_stall;
  logic [ByteW-1:0]   out_byte;
  logic [StatW-1:0]   out_status;
  logic               out_last;

  int outstanding;
  int fail_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_off_req  = 1'b0;
  int items_sent    = 0;
  int cycles        = 0;

  // what the stimulus currently assumes the registers hold
  logic [ByteW-1:0] sync_cfg [3];
  logic [ByteW-1:0] type_cfg;
  logic [LenW-1:0]  len_cfg;

  sync_frame_receiver_fletcher8_core #(
    .MAX_MESSAGE_BYTES(MaxMsg)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .rx_fault_i  (rx_fault),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_status_o(out_status),
    .out_last_o  (out_last)
  );

  sfr_frame_checker #(
    .MAX_MESSAGE_BYTES(MaxMsg)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .rx_byte_i    (rx_byte),
    .rx_fault_i   (rx_fault),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .out_status_i (out_status),
    .out_last_i   (out_last),
    .outstanding_o(outstanding),
    .errors_o     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("sync_frame_receiver_fletcher8_core verification failed");
    $finish;
  end

  // sink side: random stall, plus one long hold-off on request
  initial begin : sink_stall
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // one rx beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [ByteW-1:0] b, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    rx_fault <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // the enable goes idle after each write so it never toggles in a step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgSyncFirst:  sync_cfg[0] = val;
      CfgSyncSecond: sync_cfg[1] = val;
      CfgSyncThird:  sync_cfg[2] = val;
      CfgAcceptType: type_cfg    = val;
      CfgMsgLength:  len_cfg     = val[LenW-1:0];
      default: ;
    endcase
  endtask

  // drop valid and wait until every predicted beat has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // {sum_high, sum_low} over type and payload bytes
  function automatic logic [15:0] fletcher_pair(input logic [ByteW-1:0] bytes_q[$]);
    logic [ByteW-1:0] lo, hi;
    lo = '0;
    hi = '0;
    foreach (bytes_q[i]) begin
      lo = lo + bytes_q[i];
      hi = hi + lo;
    end
    return {hi, lo};
  endfunction

  task automatic send_frame(input frame_kind_e kind);
    logic [ByteW-1:0] seq[$];
    logic [ByteW-1:0] body[$];
    logic [15:0]      ck;
    int               n, cut;
    if (kind == FrNoise) begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 0; i < 3; i++) seq.push_back(sync_cfg[i]);
      if (kind == FrBadType) begin
        seq.push_back(type_cfg ^ 8'($urandom_range(1, 255)));
      end else begin
        n = (len_cfg == 0) ? 1 : (len_cfg > MaxMsg) ? MaxMsg : int'(len_cfg);
        body.push_back(type_cfg);
        for (int i = 1; i < n; i++) body.push_back(8'($urandom_range(255)));
        ck = fletcher_pair(body);
        if (kind == FrBadSum) begin
          if ($urandom_range(1)) ck[7:0] = ck[7:0] ^ 8'($urandom_range(1, 255));
          else ck[15:8] = ck[15:8] ^ 8'($urandom_range(1, 255));
        end
        foreach (body[i]) seq.push_back(body[i]);
        seq.push_back(ck[7:0]);
        seq.push_back(ck[15:8]);
      end
    end
    // a fault cuts the frame at a random point, sync bytes included
    cut = (kind == FrFault) ? int'($urandom_range(seq.size() - 1)) : seq.size();
    for (int i = 0; i < cut; i++) send_beat(seq[i], 1'b0);
    if (kind == FrFault) send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] part_q[$];
    logic [ByteW-1:0] new_sync [3];
    logic [ByteW-1:0] new_type;
    logic [LenW-1:0]  len_pick;
    logic [15:0]      ck;
    int               target, pick;

    cfg_we    <= 1'b0;
    cfg_idx   <= CfgSyncFirst;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    rx_fault  <= 1'b0;
    rst_n     <= 1'b0;
    sync_cfg  = '{8'h00, 8'h00, 8'h00};
    type_cfg  = 8'h00;
    len_cfg   = 6'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: all-zero sync, so one zero byte syncs; 1-byte frame
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    // link fault while hunting, byte ignored
    send_beat(8'hFF, 1'b1);
    settle();

    // extreme register values; length 0 acts as 1
    write_reg(CfgSyncFirst, 8'hFF);
    write_reg(CfgSyncSecond, 8'h00);
    write_reg(CfgSyncThird, 8'hFF);
    write_reg(CfgAcceptType, 8'hFF);
    write_reg(CfgMsgLength, 8'hC0);
    send_frame(FrGood);
    send_frame(FrBadType);
    send_frame(FrBadSum);
    settle();

    // length lowered mid-frame below the count already reached
    write_reg(CfgMsgLength, 8'h04);
    part_q = '{8'hFF, 8'hAA, 8'h55};
    for (int i = 0; i < 3; i++) send_beat(sync_cfg[i], 1'b0);
    foreach (part_q[i]) send_beat(part_q[i], 1'b0);
    settle();
    write_reg(CfgMsgLength, 8'h82);
    send_beat(8'h01, 1'b0);
    part_q.push_back(8'h01);
    ck = fletcher_pair(part_q);
    send_beat(ck[7:0], 1'b0);
    send_beat(ck[15:8], 1'b0);
    settle();

    // random frames over four idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 76;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 76;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      case (ph)
        1: begin
          new_sync = '{8'hFF, 8'hFF, 8'hFF};
          new_type = 8'hFF;
        end
        2: begin
          new_sync = '{8'h00, 8'hFF, 8'h00};
          new_type = 8'h00;
        end
        default: begin
          foreach (new_sync[i]) new_sync[i] = 8'($urandom_range(255));
          new_type = 8'($urandom_range(255));
        end
      endcase
      write_reg(CfgSyncFirst, new_sync[0]);
      write_reg(CfgSyncSecond, new_sync[1]);
      write_reg(CfgSyncThird, new_sync[2]);
      write_reg(CfgAcceptType, new_type);
      // sink holds off while frames keep coming, so the core backs up
      if (ph == 0) hold_off_req = 1'b1;
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        repeat (3) begin
          pick = $urandom_range(99);
          if (pick < 70)      send_frame(FrGood);
          else if (pick < 78) send_frame(FrBadSum);
          else if (pick < 85) send_frame(FrBadType);
          else if (pick < 93) send_frame(FrFault);
          else                send_frame(FrNoise);
        end
        settle();
        // mostly short frames, now and then the extremes
        pick = $urandom_range(19);
        if (pick == 0)      len_pick = 6'd63;
        else if (pick == 1) len_pick = 6'd32;
        else if (pick == 2) len_pick = 6'd0;
        else                len_pick = 6'($urandom_range(1, 8));
        write_reg(CfgMsgLength, {2'($urandom_range(3)), len_pick});
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("sync_frame_receiver_fletcher8_core verification clean");
    else
      $display("sync_frame_receiver_fletcher8_core verification failed");
    $finish;
  end

endmodule
